/* hdl/bce_pkg.sv */
package bce_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int DEF_MAX_BANDS = 8;
  localparam int DEF_MAX_CHANNELS = 8;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_COEF = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_GAIN = 2'd1;
  localparam logic [1:0] REG_BANDS = 2'd2;
  localparam logic [1:0] REG_CHANNELS = 2'd3;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic [2:0]                    channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          last_in;
    logic [5:0]                    coef_addr;
    logic signed [31:0]            coef_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [2:0]                    channel_out;
    logic                          last_out;
  } out_beat_t;

endpackage

/* hdl/biquad_cascade_equalizer_core.sv */
// sample beat, filtering on: states PRE, PREC, then B0 to B9 for each band, then DONE
// bypassed or unused-channel sample: straight to DONE; coefficient or clear beat: stays in IDLE
// one shared signed multiplier does every product in turn, so input is taken only when idle
// a result waiting in the output register does not hold off the next input beat
// reset: control registers to their reset values (datapath registers are not reset), history valid bits cleared at once
// coefficient memory is undefined until written
module biquad_cascade_equalizer_core #(
  parameter int MAX_BANDS = bce_pkg::DEF_MAX_BANDS,
  parameter int MAX_CHANNELS = bce_pkg::DEF_MAX_CHANNELS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bce_pkg::in_beat_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bce_pkg::out_beat_t out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int SB = bce_pkg::SAMPLE_BITS;
  localparam int SFRAC = SB - 4;
  localparam int AW = (SB > 25) ? SB : 25;
  localparam int PW = AW + 32;
  localparam int ACCW = 60;
  localparam int NCOEF = 5 * MAX_BANDS;
  localparam int CAW = (NCOEF > 1) ? $clog2(NCOEF) : 1;
  localparam int DD = MAX_BANDS * MAX_CHANNELS;
  localparam int DAW = (DD > 1) ? $clog2(DD) : 1;
  localparam int BCW = $clog2(MAX_BANDS + 1);
  localparam int SHR = (SFRAC < 25) ? 25 - SFRAC : 0;
  localparam int SHL = (SFRAC > 25) ? SFRAC - 25 : 0;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRE = 4'd1;
  localparam logic [3:0] S_PREC = 4'd2;
  localparam logic [3:0] S_B0 = 4'd3;
  localparam logic [3:0] S_B1 = 4'd4;
  localparam logic [3:0] S_B2 = 4'd5;
  localparam logic [3:0] S_B3 = 4'd6;
  localparam logic [3:0] S_B4 = 4'd7;
  localparam logic [3:0] S_B5 = 4'd8;
  localparam logic [3:0] S_B6 = 4'd9;
  localparam logic [3:0] S_B7 = 4'd10;
  localparam logic [3:0] S_B8 = 4'd11;
  localparam logic [3:0] S_B9 = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_q, state_d;
  logic        en_q;
  logic [19:0] gain_q;
  logic [3:0]  bands_q, chans_q;
  logic [BCW-1:0] band_q;
  logic [DD-1:0]  valid_q;
  logic           vld_q;
  logic           out_valid_q;

  bce_pkg::in_beat_t  item_q;
  bce_pkg::out_beat_t out_q;
  logic signed [SB-1:0]   y_q;
  logic signed [PW-1:0]   prod_q, lo_q;
  logic signed [ACCW-1:0] d1_q, d2_q, m_q, acc1_q, acc2_q;

  logic in_acc, cfg_wr;
  logic [BCW-1:0] nb;
  logic [3:0] nch;
  logic [DAW-1:0] didx;
  logic [CAW-1:0] craddr;
  logic [31:0] crd;
  logic [95:0] drd, dwdata;
  logic coef_we, del_we;
  int ksel;
  logic signed [AW-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd_pre, rnd_sf;
  logic signed [SB-1:0] pre_y;
  logic signed [ACCW-1:0] rsf;
  logic signed [87:0] mc_sum;
  logic signed [ACCW-1:0] mq;
  logic band_ok;
  logic signed [ACCW-1:0] mclamp, mrnd;
  logic signed [SB-1:0] band_y;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

  always_comb begin
    case (paddr[3:2])
      bce_pkg::REG_ENABLE: prdata = {31'd0, en_q};
      bce_pkg::REG_GAIN: prdata = {12'd0, gain_q};
      bce_pkg::REG_BANDS: prdata = {28'd0, bands_q};
      bce_pkg::REG_CHANNELS: prdata = {28'd0, chans_q};
      default: prdata = 32'd0;
    endcase
  end

  assign nb = (int'(bands_q) > MAX_BANDS) ? BCW'(MAX_BANDS) : BCW'(bands_q);
  always_comb begin
    if (chans_q == 4'd0) begin
      nch = 4'd1;
    end else if (int'(chans_q) > MAX_CHANNELS) begin
      nch = 4'(MAX_CHANNELS);
    end else begin
      nch = chans_q;
    end
  end

  assign didx = DAW'(int'(band_q) * MAX_CHANNELS + int'(item_q.channel));

  always_comb begin
    case (state_q)
      S_B0: ksel = 0;
      S_B1: ksel = 1;
      S_B2: ksel = 2;
      S_B3, S_B4: ksel = 3;
      default: ksel = 4;
    endcase
  end
  assign craddr = CAW'(int'(band_q) * 5 + ksel);

  assign coef_we = in_acc && (in_i.req_type == bce_pkg::REQ_COEF)
                   && (int'(in_i.coef_addr) < NCOEF);

  bce_ram #(.WIDTH(32), .DEPTH(NCOEF)) u_coef (
    .clk_i  (clk_i),
    .we_i   (coef_we),
    .waddr_i(CAW'(in_i.coef_addr)),
    .wdata_i(in_i.coef_value),
    .raddr_i(craddr),
    .rdata_o(crd)
  );

  assign del_we = (state_q == S_B9);
  assign dwdata = band_ok ? {acc1_q[47:0], acc2_q[47:0]} : 96'd0;

  bce_ram #(.WIDTH(96), .DEPTH(DD)) u_delay (
    .clk_i  (clk_i),
    .we_i   (del_we),
    .waddr_i(didx),
    .wdata_i(dwdata),
    .raddr_i(didx),
    .rdata_o(drd)
  );

  always_comb begin
    case (state_q)
      S_PRE: begin
        mul_a = AW'(item_q.sample_in);
        mul_b = {12'd0, gain_q};
      end
      S_B4, S_B6: begin
        mul_a = AW'($signed({1'b0, m_q[23:0]}));
        mul_b = crd;
      end
      S_B5, S_B7: begin
        mul_a = AW'($signed(m_q[48:24]));
        mul_b = crd;
      end
      default: begin
        mul_a = AW'(y_q);
        mul_b = crd;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign rnd_pre = (prod_q + PW'(33'sd1 <<< 15)) >>> 16;
  always_comb begin
    if (rnd_pre > PW'(64'sd1 <<< (SB - 2))) begin
      pre_y = SB'(64'sd1 <<< (SB - 2));
    end else if (rnd_pre < -PW'(64'sd1 <<< (SB - 2))) begin
      pre_y = SB'(-(64'sd1 <<< (SB - 2)));
    end else begin
      pre_y = SB'(rnd_pre);
    end
  end

  assign rnd_sf = (prod_q + PW'(64'sd1 <<< (SFRAC - 1))) >>> SFRAC;
  assign rsf = ACCW'(rnd_sf);

  assign mc_sum = (88'(prod_q) <<< 24) + 88'(lo_q) + 88'(64'sd1 <<< 24);
  assign mq = ACCW'(mc_sum >>> 25);

  assign band_ok = ((&m_q[ACCW-1:47]) || !(|m_q[ACCW-1:47]))
                && ((&acc1_q[ACCW-1:47]) || !(|acc1_q[ACCW-1:47]))
                && ((&acc2_q[ACCW-1:47]) || !(|acc2_q[ACCW-1:47]));

  always_comb begin
    if (m_q > ACCW'(64'sd4 <<< 25)) begin
      mclamp = ACCW'(64'sd4 <<< 25);
    end else if (m_q < -ACCW'(64'sd4 <<< 25)) begin
      mclamp = -ACCW'(64'sd4 <<< 25);
    end else begin
      mclamp = m_q;
    end
    if (SHR > 0) begin
      mrnd = (mclamp + ACCW'(64'sd1 <<< (SHR > 0 ? SHR - 1 : 0))) >>> SHR;
    end else begin
      mrnd = mclamp <<< SHL;
    end
    band_y = SB'(mrnd);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.req_type == bce_pkg::REQ_SAMPLE) begin
          if (en_q && ({1'b0, in_i.channel} < nch)) begin
            state_d = S_PRE;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PRE: state_d = S_PREC;
      S_PREC: state_d = (nb == '0) ? S_DONE : S_B0;
      S_B0: state_d = S_B1;
      S_B1: state_d = S_B2;
      S_B2: state_d = S_B3;
      S_B3: state_d = S_B4;
      S_B4: state_d = S_B5;
      S_B5: state_d = S_B6;
      S_B6: state_d = S_B7;
      S_B7: state_d = S_B8;
      S_B8: state_d = S_B9;
      S_B9: state_d = (band_q + 1'b1 == nb) ? S_DONE : S_B0;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      en_q <= 1'b0;
      gain_q <= 20'd65536;
      bands_q <= 4'd0;
      chans_q <= 4'd2;
      band_q <= '0;
      valid_q <= '0;
      vld_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          bce_pkg::REG_ENABLE: en_q <= pwdata[0];
          bce_pkg::REG_GAIN: gain_q <= pwdata[19:0];
          bce_pkg::REG_BANDS: bands_q <= pwdata[3:0];
          bce_pkg::REG_CHANNELS: chans_q <= pwdata[3:0];
          default: ;
        endcase
      end
      if (in_acc && in_i.req_type == bce_pkg::REQ_CLEAR) begin
        valid_q <= '0;
      end
      if (state_q == S_PREC) begin
        band_q <= '0;
      end
      if (state_q == S_B0) begin
        vld_q <= valid_q[didx];
      end
      if (state_q == S_B9) begin
        valid_q[didx] <= 1'b1;
        band_q <= band_q + 1'b1;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_i;
      y_q <= in_i.sample_in;
    end
    prod_q <= prod;
    case (state_q)
      S_PREC: y_q <= pre_y;
      S_B1: begin
        d1_q <= vld_q ? ACCW'($signed(drd[95:48])) : '0;
        d2_q <= vld_q ? ACCW'($signed(drd[47:0])) : '0;
      end
      S_B2: m_q <= rsf + d1_q;
      S_B3: acc1_q <= rsf + d2_q;
      S_B4: acc2_q <= rsf;
      S_B5, S_B7: lo_q <= prod_q;
      S_B6: acc1_q <= acc1_q - mq;
      S_B8: acc2_q <= acc2_q - mq;
      S_B9: y_q <= band_ok ? band_y : '0;
      default: ;
    endcase
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_q.sample_out <= y_q;
      out_q.channel_out <= item_q.channel;
      out_q.last_out <= item_q.last_in;
    end
  end

endmodule

/* hdl/bce_ram.sv */
module bce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int NBANDS = bce_pkg::DEF_MAX_BANDS;
  localparam int NCH = bce_pkg::DEF_MAX_CHANNELS;
  localparam int SFRAC = bce_pkg::SAMPLE_BITS - 4;
  localparam int CFRAC = 25;
  localparam int SETTLE = 3 + 10 * NBANDS + 1 + 20;
  localparam int IBW = $bits(bce_pkg::in_beat_t);
  localparam longint CYCLE_LIMIT = 800000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  bce_pkg::in_beat_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  bce_pkg::out_beat_t out_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  biquad_cascade_equalizer_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the block
  logic [31:0] coef_mem [5*NBANDS];
  longint hist_one [NBANDS*NCH];
  longint hist_two [NBANDS*NCH];
  logic eq_on = 1'b0;
  logic [19:0] gain = 20'd65536;
  logic [3:0] bands = 4'd0;
  logic [3:0] chans = 4'd2;

  bce_pkg::in_beat_t pending_beats[$];
  bce_pkg::out_beat_t expected_beats[$];
  int errors = 0;
  bit quiet = 1'b0;
  longint cycles = 0;

  function automatic void queue_beat(bce_pkg::in_beat_t b);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic longint round_shift(logic signed [95:0] v, int s);
    logic signed [95:0] t;
    t = v + (96'sd1 <<< (s - 1));
    t = t >>> s;
    return t[63:0];
  endfunction

  function automatic longint clamp(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic bit fits48(longint v);
    return v >= -(64'sd1 <<< 47) && v <= (64'sd1 <<< 47) - 1;
  endfunction

  function automatic void equalize(bce_pkg::in_beat_t b);
    logic signed [95:0] xw, cw, mw;
    longint y, m, n1, n2, k0, k1, k2, k3, k4;
    int nch, nb, idx;
    bce_pkg::out_beat_t r;
    case (b.req_type)
      bce_pkg::REQ_COEF: begin
        if (b.coef_addr < 5 * NBANDS) coef_mem[b.coef_addr] = b.coef_value;
      end
      bce_pkg::REQ_CLEAR: begin
        foreach (hist_one[i]) begin
          hist_one[i] = 0;
          hist_two[i] = 0;
        end
      end
      bce_pkg::REQ_SAMPLE: begin
        nch = chans == 0 ? 1 : (chans > NCH ? NCH : chans);
        nb = bands > NBANDS ? NBANDS : bands;
        y = b.sample_in;
        if (eq_on && b.channel < nch) begin
          xw = y;
          cw = {76'd0, gain};
          y = clamp(round_shift(xw * cw, 16), 64'sd4 <<< SFRAC);
          for (int bi = 0; bi < nb; bi++) begin
            idx = bi * NCH + b.channel;
            k0 = $signed(coef_mem[bi*5]);
            k1 = $signed(coef_mem[bi*5+1]);
            k2 = $signed(coef_mem[bi*5+2]);
            k3 = $signed(coef_mem[bi*5+3]);
            k4 = $signed(coef_mem[bi*5+4]);
            xw = y;
            cw = k0;
            m = round_shift(xw * cw, SFRAC) + hist_one[idx];
            if (!fits48(m)) begin
              hist_one[idx] = 0;
              hist_two[idx] = 0;
              y = 0;
              continue;
            end
            mw = m;
            cw = k1;
            n1 = round_shift(xw * cw, SFRAC);
            cw = k3;
            n1 = n1 - round_shift(mw * cw, CFRAC) + hist_two[idx];
            cw = k2;
            n2 = round_shift(xw * cw, SFRAC);
            cw = k4;
            n2 = n2 - round_shift(mw * cw, CFRAC);
            if (!fits48(n1) || !fits48(n2)) begin
              hist_one[idx] = 0;
              hist_two[idx] = 0;
              y = 0;
              continue;
            end
            hist_one[idx] = n1;
            hist_two[idx] = n2;
            y = round_shift(clamp(m, 64'sd4 <<< CFRAC), CFRAC - SFRAC);
          end
        end
        r.sample_out = y[bce_pkg::SAMPLE_BITS-1:0];
        r.channel_out = b.channel;
        r.last_out = b.last_in;
        expected_beats.insert(expected_beats.size(), r);
      end
      default: ;
    endcase
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) equalize(in_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            in_gap <= $urandom_range(1, 5) - 1;
            in_valid_i <= 1'b0;
          end else begin
            in_i <= pending_beats.pop_front();
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  int out_gap = 0;
  int out_seen = 0;
  bit held = 1'b0;
  bce_pkg::out_beat_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_seen <= out_seen + 1;
        if (expected_beats.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected beat %h", $time, out_o);
        end else begin
          want = expected_beats.pop_front();
          if (want.sample_out !== out_o.sample_out) begin
            errors = errors + 1;
            $display("%0t: sample_out expected %h actual %h", $time, want.sample_out,
                     out_o.sample_out);
          end
          if (want.channel_out !== out_o.channel_out) begin
            errors = errors + 1;
            $display("%0t: channel_out expected %h actual %h", $time, want.channel_out,
                     out_o.channel_out);
          end
          if (want.last_out !== out_o.last_out) begin
            errors = errors + 1;
            $display("%0t: last_out expected %h actual %h", $time, want.last_out,
                     out_o.last_out);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!held && out_seen == 200) begin
        held <= 1'b1;
        out_gap <= 2000;
        out_ready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 5) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_valid_i || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bce_pkg::REG_ENABLE: eq_on = val[0];
      bce_pkg::REG_GAIN: gain = val[19:0];
      bce_pkg::REG_BANDS: bands = val[3:0];
      default: chans = val[3:0];
    endcase
  endtask

  task automatic set_all(logic en, logic [31:0] g, logic [31:0] nb, logic [31:0] nc);
    wait_idle();
    reg_write(bce_pkg::REG_ENABLE, {31'($urandom), en});
    reg_write(bce_pkg::REG_GAIN, g);
    reg_write(bce_pkg::REG_BANDS, nb);
    reg_write(bce_pkg::REG_CHANNELS, nc);
  endtask

  function automatic bce_pkg::in_beat_t noise_beat();
    bce_pkg::in_beat_t b;
    b = IBW'({$urandom, $urandom, $urandom});
    return b;
  endfunction

  function automatic bce_pkg::in_beat_t sample_beat(logic [2:0] ch, logic signed [23:0] s);
    bce_pkg::in_beat_t b;
    b = noise_beat();
    b.req_type = bce_pkg::REQ_SAMPLE;
    b.channel = ch;
    b.sample_in = s;
    return b;
  endfunction

  function automatic bce_pkg::in_beat_t coef_beat(logic [5:0] a, logic [31:0] v);
    bce_pkg::in_beat_t b;
    b = noise_beat();
    b.req_type = bce_pkg::REQ_COEF;
    b.coef_addr = a;
    b.coef_value = v;
    return b;
  endfunction

  function automatic logic [31:0] mild_coef();
    return $signed($urandom) >>> $urandom_range(7, 10);
  endfunction

  function automatic bce_pkg::in_beat_t random_beat();
    bce_pkg::in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 84) begin
      b = sample_beat(3'($urandom), 24'($urandom));
      case ($urandom_range(0, 9))
        0: b.sample_in = 24'h7fffff;
        1: b.sample_in = 24'h800000;
        2: b.sample_in = $signed(24'($urandom)) >>> 6;
        default: ;
      endcase
    end else if (pick < 93) begin
      b = coef_beat(6'($urandom_range(0, 63)),
                    $urandom_range(0, 9) == 0 ? $urandom : mild_coef());
    end else if (pick < 97) begin
      b = noise_beat();
      b.req_type = bce_pkg::REQ_CLEAR;
    end else begin
      b = noise_beat();
      b.req_type = 2'd3;
    end
    return b;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) queue_beat(random_beat());
  endtask

  initial begin
    bce_pkg::in_beat_t b;
    foreach (hist_one[i]) begin
      hist_one[i] = 0;
      hist_two[i] = 0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // load every coefficient with a tame filter before anything can read one
    for (int a = 0; a < 5 * NBANDS; a++)
      queue_beat(coef_beat(6'(a), (a % 5 == 0) ? 32'h0200_0000 + mild_coef()
                                              : mild_coef()));
    // directed, bypassed at reset settings
    queue_beat(sample_beat(3'd0, 24'h7fffff));
    queue_beat(sample_beat(3'd7, 24'h800000));
    set_all(1'b1, 32'hfffff, 32'd8, 32'd8);
    queue_beat(sample_beat(3'd0, 24'h7fffff));
    queue_beat(sample_beat(3'd7, 24'h800000));
    queue_beat(sample_beat(3'd3, 24'h000000));
    queue_beat(sample_beat(3'd1, 24'h000001));
    queue_beat(sample_beat(3'd2, 24'hffffff));
    b = noise_beat();
    b.req_type = 2'd3;
    queue_beat(b);
    queue_beat(coef_beat(6'd63, 32'hffffffff));
    queue_beat(coef_beat(6'd40, 32'h80000000));
    b = noise_beat();
    b.req_type = bce_pkg::REQ_CLEAR;
    queue_beat(b);
    queue_beat(sample_beat(3'd5, 24'h400000));
    // unstable band to force history overflow
    queue_beat(coef_beat(6'd0, 32'h7fffffff));
    queue_beat(coef_beat(6'd3, 32'h80000000));
    queue_beat(coef_beat(6'd4, 32'h7fffffff));
    for (int i = 0; i < 8; i++) queue_beat(sample_beat(3'd0, 24'h7fffff));
    set_all(1'b1, 32'd0, 32'd1, 32'd1);
    queue_beat(sample_beat(3'd0, 24'h123456));
    queue_beat(sample_beat(3'd1, 24'h123456));

    set_all(1'b1, 32'd65536, 32'd8, 32'd8);
    random_phase(200);
    set_all(1'b1, 32'hfffff, 32'd15, 32'd0);
    random_phase(150);
    set_all(1'b1, $urandom_range(0, 200000), 32'd2, 32'd15);
    random_phase(200);
    set_all(1'b0, $urandom, $urandom, $urandom);
    random_phase(100);
    set_all(1'b1, 32'd0, 32'd0, 32'd4);
    random_phase(100);
    set_all(1'b1, $urandom_range(30000, 140000), $urandom_range(0, 15), $urandom_range(0, 15));
    random_phase(200);
    set_all(1'b1, 32'd65536, 32'd3, 32'd8);
    random_phase(200);
    set_all(1'b1, $urandom_range(0, 1048575), 32'd8, 32'd2);
    wait_idle();
    quiet = 1'b1;
    random_phase(250);
    wait_idle();
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
hdl/bce_pkg.sv
hdl/bce_ram.sv
hdl/biquad_cascade_equalizer_core.sv
sim/tb.sv
